@@ hw/rtl/v3a_pkg.sv @@
// v3a_pkg: shared types and codes for the 3d vector arithmetic unit
// no dependencies; imported by every rtl file of the unit
`timescale 1ns / 1ps
`default_nettype none

package v3a_pkg;

    // operation codes
    localparam logic [2:0] FN_ADD   = 3'd0;
    localparam logic [2:0] FN_SUB   = 3'd1;
    localparam logic [2:0] FN_DOT   = 3'd2;
    localparam logic [2:0] FN_CROSS = 3'd3;
    localparam logic [2:0] FN_SCALE = 3'd4;
    localparam logic [2:0] FN_MAG   = 3'd5;
    localparam logic [2:0] FN_NORM  = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale;
    } v3a_in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic [1:0]         status;
    } v3a_out_t;

    // result fields that ride along the sqrt and divide pipelines
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic [1:0]         status;
    } v3a_side_t;

endpackage

`default_nettype wire

@@ hw/rtl/v3a_isqrt.sv @@
// v3a_isqrt: pipelined digit-by-digit integer square root, one root bit per stage
// depends on v3a_pkg for the side payload type
`timescale 1ns / 1ps
`default_nettype none

module v3a_isqrt #(
    parameter int RW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [2*RW-1:0]       in_n,
    input  v3a_pkg::v3a_side_t    in_side,
    output logic                  out_valid,
    output logic [RW-1:0]         out_root,
    output logic [RW:0]           out_rem,
    output v3a_pkg::v3a_side_t    out_side
);
    import v3a_pkg::*;

    localparam int NB = 2 * RW;

    logic              v_reg    [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [RW:0]       rem_reg  [RW];
    logic [NB-1:0]     n_reg    [RW];
    v3a_side_t         side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            v_in;
        logic [RW-1:0]   root_in;
        logic [RW:0]     rem_in;
        logic [NB-1:0]   n_in;
        v3a_side_t       side_in;
        logic [RW+2:0]   rs;
        logic [RW+1:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign root_in = '0;
            assign rem_in  = '0;
            assign n_in    = in_n;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign n_in    = n_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next two radicand bits and try 4*root+1
        assign rs    = {rem_in, n_in[NB-1:NB-2]};
        assign trial = {root_in, 2'b01};
        assign ge    = rs >= (RW+3)'(trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                root_reg[k] <= {root_in[RW-2:0], ge};
                rem_reg[k]  <= ge ? (RW+1)'(rs - (RW+3)'(trial)) : (RW+1)'(rs);
                n_reg[k]    <= n_in << 2;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_rem   = rem_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

`default_nettype wire

@@ hw/rtl/v3a_div.sv @@
// v3a_div: three-lane pipelined restoring divider sharing one divisor
// one quotient bit per stage; depends on v3a_pkg for the side payload type
`timescale 1ns / 1ps
`default_nettype none

module v3a_div #(
    parameter int MW = 33,
    parameter int QW = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [MW-1:0]           in_m,
    input  logic [MW+QW-2:0]        in_num [3],
    input  v3a_pkg::v3a_side_t      in_side,
    output logic                    out_valid,
    output logic [QW-1:0]           out_q [3],
    output logic [MW-1:0]           out_m,
    output v3a_pkg::v3a_side_t      out_side
);
    import v3a_pkg::*;

    localparam int NW = MW + QW - 1;

    logic            v_reg    [QW];
    logic [MW-1:0]   m_reg    [QW];
    logic [MW-1:0]   rem_reg  [QW][3];
    logic [QW-1:0]   low_reg  [QW][3];
    logic [QW-1:0]   q_reg    [QW][3];
    v3a_side_t       side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            v_in;
        logic [MW-1:0]   m_in;
        v3a_side_t       side_in;
        logic [MW-1:0]   rem_in [3];
        logic [QW-1:0]   low_in [3];
        logic [QW-1:0]   q_in   [3];
        logic [MW:0]     rs     [3];
        logic            ge     [3];

        if (k == 0) begin : g_first
            // quotient is known to fit in QW bits, so the top part is already below m
            always_comb
            begin
                v_in    = in_valid;
                m_in    = in_m;
                side_in = in_side;
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = MW'(in_num[l][NW-1:QW]);
                    low_in[l] = in_num[l][QW-1:0];
                    q_in[l]   = '0;
                end
            end
        end else begin : g_next
            always_comb
            begin
                v_in    = v_reg[k-1];
                m_in    = m_reg[k-1];
                side_in = side_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = rem_reg[k-1][l];
                    low_in[l] = low_reg[k-1][l];
                    q_in[l]   = q_reg[k-1][l];
                end
            end
        end

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                rs[l] = {rem_in[l], low_in[l][QW-1]};
                ge[l] = rs[l] >= {1'b0, m_in};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[k]    <= m_in;
                side_reg[k] <= side_in;
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[k][l] <= ge[l] ? MW'(rs[l] - {1'b0, m_in}) : rs[l][MW-1:0];
                    low_reg[k][l] <= low_in[l] << 1;
                    q_reg[k][l]   <= {q_in[l][QW-2:0], ge[l]};
                end
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_m     = m_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign out_q[0]  = q_reg[QW-1][0];
    assign out_q[1]  = q_reg[QW-1][1];
    assign out_q[2]  = q_reg[QW-1][2];

endmodule

`default_nettype wire

@@ hw/rtl/vector3_arith_unit.sv @@
// vector3_arith_unit: pipelined 3d vector alu in signed fixed point
// depends on v3a_pkg, v3a_isqrt and v3a_div
//
//   channel  signals                         payload
//   in       in_valid / in_ready             in_data  (v3a_in_t)
//   out      out_valid / out_ready           out_data (v3a_out_t)
//
// one transaction per cycle sustained unless the output buffer stalls; every operation
// takes the same path through 4 + OPW + 1 + (FRAC_BITS + 1) register stages ahead of
// the output buffer, most of them in the bit-per-stage square root and the
// bit-per-stage divider
// a global advance moves all stages together; a two-entry output buffer keeps input
// open while one result waits, and stalls the pipeline only when both entries are full
// reset clears the valid bits and the output buffer count and pointers; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module vector3_arith_unit #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  v3a_pkg::v3a_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output v3a_pkg::v3a_out_t   out_data
);
    import v3a_pkg::*;

    localparam int OPW = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int PW  = 2 * OPW;
    localparam int SW  = PW + 2;
    localparam int MW  = OPW + 1;
    localparam int QW  = FRAC_BITS + 1;
    localparam int NW  = MW + QW - 1;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-OPW+1){1'b0}}, {(OPW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [SW-1:0] HALF   = SW'(1) << (FRAC_BITS - 1);

    // {saturated flag, value}
    function automatic logic [OPW:0] sat_fn(input logic signed [SW-1:0] v);
        logic [OPW:0] res;
        if (v > SAT_HI)
            res = {1'b1, SAT_HI[OPW-1:0]};
        else if (v < SAT_LO)
            res = {1'b1, SAT_LO[OPW-1:0]};
        else
            res = {1'b0, v[OPW-1:0]};
        return res;
    endfunction

    logic adv;

    // ---------------- stage 0: operand select ----------------
    logic signed [OPW-1:0] a_in [3];
    logic signed [OPW-1:0] b_in [3];
    logic signed [OPW-1:0] s_in;
    logic signed [OPW-1:0] ma_c [6];
    logic signed [OPW-1:0] mb_c [6];
    logic signed [OPW:0]   as_c [3];

    always_comb
    begin
        a_in[0] = in_data.a_x[OPW-1:0];
        a_in[1] = in_data.a_y[OPW-1:0];
        a_in[2] = in_data.a_z[OPW-1:0];
        b_in[0] = in_data.b_x[OPW-1:0];
        b_in[1] = in_data.b_y[OPW-1:0];
        b_in[2] = in_data.b_z[OPW-1:0];
        s_in    = in_data.scale[OPW-1:0];
        for (int i = 0; i < 6; i++)
        begin
            ma_c[i] = '0;
            mb_c[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (in_data.func == FN_SUB)
                as_c[i] = (OPW+1)'(a_in[i]) - (OPW+1)'(b_in[i]);
            else
                as_c[i] = (OPW+1)'(a_in[i]) + (OPW+1)'(b_in[i]);
        end
        unique case (in_data.func)
            FN_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_c[i] = a_in[i];
                    mb_c[i] = b_in[i];
                end
            end
            FN_CROSS:
            begin
                ma_c[0] = a_in[1]; mb_c[0] = b_in[2];
                ma_c[1] = a_in[2]; mb_c[1] = b_in[1];
                ma_c[2] = a_in[2]; mb_c[2] = b_in[0];
                ma_c[3] = a_in[0]; mb_c[3] = b_in[2];
                ma_c[4] = a_in[0]; mb_c[4] = b_in[1];
                ma_c[5] = a_in[1]; mb_c[5] = b_in[0];
            end
            FN_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_c[i] = a_in[i];
                    mb_c[i] = s_in;
                end
            end
            FN_MAG, FN_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_c[i] = a_in[i];
                    mb_c[i] = a_in[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    logic                  v0_reg;
    logic [2:0]            op0_reg;
    logic signed [OPW-1:0] ma0_reg [6];
    logic signed [OPW-1:0] mb0_reg [6];
    logic signed [OPW:0]   as0_reg [3];
    logic signed [OPW-1:0] a0_reg  [3];

    // ---------------- stage 1: products ----------------
    logic                  v1_reg;
    logic [2:0]            op1_reg;
    logic signed [PW-1:0]  p1_reg  [6];
    logic signed [OPW:0]   as1_reg [3];
    logic signed [OPW-1:0] a1_reg  [3];

    // ---------------- stage 2: sums with rounding offset ----------------
    logic signed [SW-1:0]  pe   [6];
    logic signed [SW-1:0]  sum_c [3];
    logic [PW-1:0]         n_c;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            pe[i] = SW'(p1_reg[i]);
        for (int i = 0; i < 3; i++)
            sum_c[i] = pe[i] + HALF;
        // sum of squares is nonnegative and below 2^PW
        n_c = PW'(p1_reg[0]) + PW'(p1_reg[1]) + PW'(p1_reg[2]);
        unique case (op1_reg)
            FN_DOT:
            begin
                sum_c[0] = pe[0] + pe[1] + pe[2] + HALF;
            end
            FN_CROSS:
            begin
                sum_c[0] = pe[0] - pe[1] + HALF;
                sum_c[1] = pe[2] - pe[3] + HALF;
                sum_c[2] = pe[4] - pe[5] + HALF;
            end
            default:
            begin
            end
        endcase
    end

    logic                  v2_reg;
    logic [2:0]            op2_reg;
    logic signed [SW-1:0]  sum2_reg [3];
    logic [PW-1:0]         n2_reg;
    logic signed [OPW:0]   as2_reg [3];
    logic signed [OPW-1:0] a2_reg  [3];

    // ---------------- stage 3: shift, saturate, select ----------------
    logic signed [SW-1:0]  lin   [3];
    logic [OPW:0]          sat_l [3];
    logic [OPW:0]          sat_a [3];
    logic signed [OPW-1:0] r3    [3];
    logic                  f3;
    v3a_side_t             side3_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lin[i]   = sum2_reg[i] >>> FRAC_BITS;
            sat_l[i] = sat_fn(lin[i]);
            sat_a[i] = sat_fn(SW'(as2_reg[i]));
            r3[i]    = '0;
        end
        f3 = 1'b0;
        unique case (op2_reg)
            FN_ADD, FN_SUB:
            begin
                for (int i = 0; i < 3; i++)
                    r3[i] = sat_a[i][OPW-1:0];
                f3 = sat_a[0][OPW] | sat_a[1][OPW] | sat_a[2][OPW];
            end
            FN_DOT:
            begin
                r3[0] = sat_l[0][OPW-1:0];
                f3    = sat_l[0][OPW];
            end
            FN_CROSS, FN_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    r3[i] = sat_l[i][OPW-1:0];
                f3 = sat_l[0][OPW] | sat_l[1][OPW] | sat_l[2][OPW];
            end
            FN_MAG, FN_NORM:
            begin
                // vector a rides along for the later stages
                for (int i = 0; i < 3; i++)
                    r3[i] = a2_reg[i];
            end
            default:
            begin
            end
        endcase
        side3_c.op     = op2_reg;
        side3_c.r_x    = 32'(r3[0]);
        side3_c.r_y    = 32'(r3[1]);
        side3_c.r_z    = 32'(r3[2]);
        side3_c.status = f3 ? ST_SAT : ST_OK;
    end

    logic          v3_reg;
    v3a_side_t     side3_reg;
    logic [PW-1:0] n3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg <= in_data.func;
            for (int i = 0; i < 6; i++)
            begin
                ma0_reg[i] <= ma_c[i];
                mb0_reg[i] <= mb_c[i];
                p1_reg[i]  <= PW'(ma0_reg[i]) * PW'(mb0_reg[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                as0_reg[i]  <= as_c[i];
                a0_reg[i]   <= a_in[i];
                as1_reg[i]  <= as0_reg[i];
                a1_reg[i]   <= a0_reg[i];
                as2_reg[i]  <= as1_reg[i];
                a2_reg[i]   <= a1_reg[i];
                sum2_reg[i] <= sum_c[i];
            end
            op1_reg   <= op0_reg;
            op2_reg   <= op1_reg;
            n2_reg    <= n_c;
            side3_reg <= side3_c;
            n3_reg    <= n2_reg;
        end
    end

    // ---------------- square root ----------------
    logic          vq;
    logic [OPW-1:0] root_q;
    logic [OPW:0]   rem_q;
    v3a_side_t      side_q;

    v3a_isqrt #(
        .RW(OPW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v3_reg),
        .in_n      (n3_reg),
        .in_side   (side3_reg),
        .out_valid (vq),
        .out_root  (root_q),
        .out_rem   (rem_q),
        .out_side  (side_q)
    );

    // ---------------- round magnitude, build numerators ----------------
    logic [MW-1:0]         m_c;
    logic [OPW:0]          sat_m;
    logic [OPW-1:0]        a_u   [3];
    logic [OPW-1:0]        a_abs [3];
    logic [NW-1:0]         num_c [3];
    v3a_side_t             side_r_c;

    always_comb
    begin
        // round up when n exceeds root^2 + root
        m_c   = MW'(root_q) + MW'(rem_q > MW'(root_q));
        sat_m = sat_fn(SW'(m_c));
        a_u[0] = side_q.r_x[OPW-1:0];
        a_u[1] = side_q.r_y[OPW-1:0];
        a_u[2] = side_q.r_z[OPW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            a_abs[i] = a_u[i][OPW-1] ? (~a_u[i] + 1'b1) : a_u[i];
            num_c[i] = (NW'(a_abs[i]) << FRAC_BITS) + NW'(m_c >> 1);
        end
        side_r_c = side_q;
        if (side_q.op == FN_MAG)
        begin
            side_r_c.r_x    = 32'(signed'(sat_m[OPW-1:0]));
            side_r_c.r_y    = '0;
            side_r_c.r_z    = '0;
            side_r_c.status = sat_m[OPW] ? ST_SAT : ST_OK;
        end
    end

    logic          vr_reg;
    logic [MW-1:0] m_r_reg;
    logic [NW-1:0] num_r_reg [3];
    v3a_side_t     side_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
        end
        else if (adv)
        begin
            vr_reg <= vq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_r_reg    <= m_c;
            side_r_reg <= side_r_c;
            for (int i = 0; i < 3; i++)
                num_r_reg[i] <= num_c[i];
        end
    end

    // ---------------- divide ----------------
    logic          vd;
    logic [QW-1:0] q_d [3];
    logic [MW-1:0] m_d;
    v3a_side_t     side_d;

    v3a_div #(
        .MW(MW),
        .QW(QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vr_reg),
        .in_m      (m_r_reg),
        .in_num    (num_r_reg),
        .in_side   (side_r_reg),
        .out_valid (vd),
        .out_q     (q_d),
        .out_m     (m_d),
        .out_side  (side_d)
    );

    // ---------------- sign, saturate normalize result ----------------
    logic                  sgn   [3];
    logic signed [SW-1:0]  qe    [3];
    logic [OPW:0]          sat_q [3];
    v3a_out_t              fin_c;

    always_comb
    begin
        sgn[0] = side_d.r_x[OPW-1];
        sgn[1] = side_d.r_y[OPW-1];
        sgn[2] = side_d.r_z[OPW-1];
        for (int i = 0; i < 3; i++)
        begin
            qe[i]    = SW'(q_d[i]);
            sat_q[i] = sat_fn(sgn[i] ? -qe[i] : qe[i]);
        end
        fin_c.r_x    = side_d.r_x;
        fin_c.r_y    = side_d.r_y;
        fin_c.r_z    = side_d.r_z;
        fin_c.status = side_d.status;
        if (side_d.op == FN_NORM)
        begin
            if (m_d == '0)
            begin
                fin_c.r_x    = '0;
                fin_c.r_y    = '0;
                fin_c.r_z    = '0;
                fin_c.status = ST_ZERO;
            end
            else
            begin
                fin_c.r_x    = 32'(signed'(sat_q[0][OPW-1:0]));
                fin_c.r_y    = 32'(signed'(sat_q[1][OPW-1:0]));
                fin_c.r_z    = 32'(signed'(sat_q[2][OPW-1:0]));
                fin_c.status = (sat_q[0][OPW] | sat_q[1][OPW] | sat_q[2][OPW])
                               ? ST_SAT : ST_OK;
            end
        end
    end

    // ---------------- two-entry output buffer ----------------
    v3a_out_t   buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign adv       = (cnt_reg != 2'd2) | out_ready;
    assign in_ready  = adv;
    assign push      = adv & vd;
    assign pop       = out_valid & out_ready;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = buf_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= fin_c;
    end

endmodule

`default_nettype wire
